// ===== src/assert_macros.svh =====
// Assertion macros shared by the date normalizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define CDN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CDN_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/cdn_pkg.sv =====
// Types, constants and helper functions of the calendar date normalizer.
package cdn_pkg;

	localparam int YEAR_W   = 16;
	localparam int MONTH_W  = 14;
	localparam int DAY_W    = 18;
	localparam int NMONTH_W = 4;
	localparam int NDAY_W   = 5;

	// working year: folded and walked years stay well inside +/-2^17
	localparam int WY_W     = 18;
	localparam int FOLD_W   = 15;
	localparam int MUL_A_W  = 17;
	localparam int MUL_B_W  = 16;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int FOLD_Q_W = 12;
	localparam int MOD_Q_W  = 9;
	localparam int MOD_W    = 9;

	// month - 1 biased by 683*12 so the fold input is never negative
	localparam logic [FOLD_W-1:0] FOLD_BIAS = 15'd8195;
	localparam logic signed [WY_W-1:0] FOLD_Q_BIAS = 18'sd683;
	localparam logic [MUL_B_W-1:0] RECIP_12  = 16'd21845;
	localparam int FOLD_SHIFT = 18;

	// year biased by 100*400 so the mod-400 input is never negative
	localparam logic [MUL_A_W-1:0] YEAR_BIAS = 17'd40000;
	localparam logic [MUL_B_W-1:0] RECIP_400 = 16'd41943;
	localparam int MOD_SHIFT = 24;
	localparam logic [MOD_W-1:0] MOD_LAST = 9'd399;

	localparam logic [NMONTH_W-1:0] JAN = 4'd1;
	localparam logic [NMONTH_W-1:0] FEB = 4'd2;
	localparam logic [NMONTH_W-1:0] DEC = 4'd12;

	localparam logic signed [WY_W-1:0] YEAR_MAX = 18'sd32767;
	localparam logic signed [WY_W-1:0] YEAR_MIN = -18'sd32768;

	localparam logic [NDAY_W-1:0] MONTH_DAYS [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};
	localparam logic [NDAY_W-1:0] LEAP_FEB_DAYS = 5'd29;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_M,
		ST_FIX_M,
		ST_MUL_Y,
		ST_FIX_Y,
		ST_WALK,
		ST_DONE
	} state_t;

	// leap test from year mod 400
	function automatic logic is_leap(input logic [MOD_W-1:0] r);
		logic cent;
		cent = (r == 9'd0) || (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
		return ((r[1:0] == 2'd0) && !cent) || (r == 9'd0);
	endfunction

	function automatic logic [NDAY_W-1:0] month_len(input logic [NMONTH_W-1:0] m,
		input logic leap);
		logic [NMONTH_W-1:0] idx;
		idx = m - JAN;
		if (m == FEB && leap)
			return LEAP_FEB_DAYS;
		else if (idx < NMONTH_W'(12))
			return MONTH_DAYS[idx];
		else
			return MONTH_DAYS[0];
	endfunction

	function automatic logic [MOD_W-1:0] mod_inc(input logic [MOD_W-1:0] r);
		return (r == MOD_LAST) ? '0 : r + 9'd1;
	endfunction

	function automatic logic [MOD_W-1:0] mod_dec(input logic [MOD_W-1:0] r);
		return (r == '0) ? MOD_LAST : r - 9'd1;
	endfunction

endpackage

// ===== src/cdn_raw_if.sv =====
// Channel carrying one raw (unnormalized) date item.
interface cdn_raw_if;
	import cdn_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [YEAR_W-1:0]  raw_year;
	logic signed [MONTH_W-1:0] raw_month;
	logic signed [DAY_W-1:0]   raw_day;

	modport source (output valid, raw_year, raw_month, raw_day, input ready);
	modport sink (input valid, raw_year, raw_month, raw_day, output ready);
endinterface

// ===== src/cdn_norm_if.sv =====
// Channel carrying one normalized date item.
interface cdn_norm_if;
	import cdn_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [YEAR_W-1:0]   norm_year;
	logic [NMONTH_W-1:0]        norm_month;
	logic [NDAY_W-1:0]          norm_day;
	logic                       year_overflow;

	modport source (output valid, norm_year, norm_month, norm_day, year_overflow,
		input ready);
	modport sink (input valid, norm_year, norm_month, norm_day, year_overflow,
		output ready);
endinterface

// ===== src/calendar_date_normalizer_core.sv =====
// Top level of the calendar date normalizer: month fold, mod-400 setup, month walk.
//
//   channel    | role | payload
//   -----------+------+----------------------------------------------
//   date_raw   | sink | raw_year s16, raw_month s14, raw_day s18
//   date_norm  | src  | norm_year s16, norm_month u4, norm_day u5, year_overflow
//
// From accept to a loaded result an item passes MUL_M, FIX_M, MUL_Y, FIX_Y, WALK
// and DONE; WALK steps N months, N being 0 to about 4310 for the full raw_day range,
// one month per cycle through the single day adder.
// date_raw.ready is high only while the sequencer is idle; one item at a time.
// The result sits in an output register, so a new item is taken while it waits.
// A stalled date_norm holds the sequencer in its last state until the slot frees.
// Reset clears the sequencer and the output valid; no memory, no clearing pass.
`include "assert_macros.svh"

module calendar_date_normalizer_core (
	input  logic clk,
	input  logic arst_n,
	cdn_raw_if.sink    date_raw,
	cdn_norm_if.source date_norm
);
	import cdn_pkg::*;

	state_t state_q, state_d;

	// working registers
	logic signed [WY_W-1:0]  y_q;
	logic [FOLD_W-1:0]       x_q;      // biased month - 1
	logic [NMONTH_W-1:0]     m_q;
	logic signed [DAY_W-1:0] d_q;
	logic [MOD_W-1:0]        r400_q;   // year mod 400, drives the leap rule
	logic [PROD_W-1:0]       prod_q;

	// shared multiplier operands
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;

	// output register
	logic                    out_valid_q;
	logic signed [YEAR_W-1:0] out_year_q;
	logic [NMONTH_W-1:0]     out_month_q;
	logic [NDAY_W-1:0]       out_day_q;
	logic                    out_ovf_q;

	logic raw_take;
	logic out_load;

	// ---------------- month fold fixup ----------------
	logic [FOLD_Q_W-1:0] fq_est, fq_fix;
	logic [FOLD_W-1:0]   fr_est, fr_fix;

	always_comb begin
		fq_est = prod_q[FOLD_SHIFT +: FOLD_Q_W];
		fr_est = x_q - ({fq_est, 3'b000} + {1'b0, fq_est, 2'b00});
		// reciprocal underestimates by at most one
		if (fr_est >= FOLD_W'(12)) begin
			fq_fix = fq_est + FOLD_Q_W'(1);
			fr_fix = fr_est - FOLD_W'(12);
		end else begin
			fq_fix = fq_est;
			fr_fix = fr_est;
		end
	end

	// ---------------- year mod 400 fixup ----------------
	logic [MUL_A_W-1:0] y_biased;
	logic [MOD_Q_W-1:0] yq_est;
	logic [MUL_A_W-1:0] yr_est, yr_fix;

	always_comb begin
		y_biased = y_q[MUL_A_W-1:0] + YEAR_BIAS;
		yq_est   = prod_q[MOD_SHIFT +: MOD_Q_W];
		yr_est   = y_biased - ({yq_est, 8'b0} + {1'b0, yq_est, 7'b0}
			+ {4'b0, yq_est, 4'b0});
		yr_fix   = (yr_est >= MUL_A_W'(400)) ? yr_est - MUL_A_W'(400) : yr_est;
	end

	// ---------------- month walk ----------------
	logic [NDAY_W-1:0]   len_cur, len_prev;
	logic [NMONTH_W-1:0] m_prev;
	logic [MOD_W-1:0]    r_prev;
	logic                walk_fwd, walk_bwd;

	always_comb begin
		len_cur  = month_len(m_q, is_leap(r400_q));
		m_prev   = (m_q == JAN) ? DEC : m_q - JAN;
		r_prev   = (m_q == JAN) ? mod_dec(r400_q) : r400_q;
		len_prev = month_len(m_prev, is_leap(r_prev));
		walk_fwd = d_q > $signed({{(DAY_W-NDAY_W){1'b0}}, len_cur});
		walk_bwd = d_q < $signed(DAY_W'(1));
	end

	// ---------------- saturation ----------------
	logic signed [YEAR_W-1:0] sat_year;
	logic                     sat_ovf;

	always_comb begin
		if (y_q > YEAR_MAX) begin
			sat_year = YEAR_MAX[YEAR_W-1:0];
			sat_ovf  = 1'b1;
		end else if (y_q < YEAR_MIN) begin
			sat_year = YEAR_MIN[YEAR_W-1:0];
			sat_ovf  = 1'b1;
		end else begin
			sat_year = y_q[YEAR_W-1:0];
			sat_ovf  = 1'b0;
		end
	end

	// ---------------- sequencer: next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (date_raw.valid) state_d = ST_MUL_M;
			ST_MUL_M: state_d = ST_FIX_M;
			ST_FIX_M: state_d = ST_MUL_Y;
			ST_MUL_Y: state_d = ST_FIX_Y;
			ST_FIX_Y: state_d = ST_WALK;
			ST_WALK:  if (!walk_fwd && !walk_bwd) state_d = ST_DONE;
			ST_DONE:  if (!out_valid_q || date_norm.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// ---------------- sequencer: outputs ----------------
	always_comb begin
		raw_take = 1'b0;
		out_load = 1'b0;
		mul_a    = {{(MUL_A_W-FOLD_W){1'b0}}, x_q};
		mul_b    = RECIP_12;
		case (state_q)
			ST_IDLE:  raw_take = date_raw.valid;
			ST_MUL_Y: begin
				mul_a = y_biased;
				mul_b = RECIP_400;
			end
			ST_DONE:  out_load = !out_valid_q || date_norm.ready;
			default:  ;
		endcase
	end

	assign date_raw.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		case (state_q)
			ST_IDLE: if (raw_take) begin
				y_q <= WY_W'(date_raw.raw_year);
				x_q <= FOLD_W'(date_raw.raw_month) + FOLD_BIAS;
				d_q <= date_raw.raw_day;
			end
			ST_FIX_M: begin
				m_q <= fr_fix[NMONTH_W-1:0] + JAN;
				y_q <= y_q + $signed({{(WY_W-FOLD_Q_W){1'b0}}, fq_fix}) - FOLD_Q_BIAS;
			end
			ST_FIX_Y: r400_q <= yr_fix[MOD_W-1:0];
			ST_WALK: begin
				if (walk_fwd) begin
					d_q <= d_q - $signed({{(DAY_W-NDAY_W){1'b0}}, len_cur});
					if (m_q == DEC) begin
						m_q    <= JAN;
						y_q    <= y_q + WY_W'(1);
						r400_q <= mod_inc(r400_q);
					end else begin
						m_q <= m_q + NMONTH_W'(1);
					end
				end else if (walk_bwd) begin
					m_q    <= m_prev;
					r400_q <= r_prev;
					d_q    <= d_q + $signed({{(DAY_W-NDAY_W){1'b0}}, len_prev});
					if (m_q == JAN)
						y_q <= y_q - WY_W'(1);
				end
			end
			default: ;
		endcase
	end

	// output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (date_norm.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_year_q  <= sat_year;
			out_month_q <= m_q;
			out_day_q   <= d_q[NDAY_W-1:0];
			out_ovf_q   <= sat_ovf;
		end
	end

	assign date_norm.valid         = out_valid_q;
	assign date_norm.norm_year     = out_year_q;
	assign date_norm.norm_month    = out_month_q;
	assign date_norm.norm_day      = out_day_q;
	assign date_norm.year_overflow = out_ovf_q;

	// ---------------- checks ----------------
	`CDN_ASSERT(a_accept_starts_fold, date_raw.valid && date_raw.ready |=> state_q == ST_MUL_M, "accept did not start the month fold")
	`CDN_ASSERT(a_walk_month_range, state_q == ST_WALK |-> m_q >= JAN && m_q <= DEC, "month left 1..12 during walk")
	`CDN_ASSERT(a_walk_mod_range, state_q == ST_WALK |-> r400_q <= MOD_LAST, "year mod 400 out of range")
	`CDN_ASSERT(a_result_sane, $rose(out_valid_q) |-> out_month_q >= JAN && out_month_q <= DEC && out_day_q != '0, "result date out of range")
	`CDN_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> state_q == ST_IDLE && !out_valid_q, "reset did not clear control state")

endmodule

// ===== test/tb_top.sv =====
// Testbench for calendar_date_normalizer_core: directed corners, random dates, scoreboard.
`timescale 1ns / 100ps

module tb_top;
	import cdn_pkg::*;

	// Accept-free cycles allowed before the run is declared hung. The longest
	// item walks about 4310 months at one per cycle, plus the setup states and
	// any output stall; this is several times that.
	localparam int WATCHDOG_LIMIT = 20000;
	// Quiet cycles after the last result, to catch a stray extra item.
	localparam int SETTLE_CYCLES  = 16;

	// Days per month, non-leap, January first.
	localparam int DAYS_PER_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct {
		logic signed [YEAR_W-1:0] year;
		logic [NMONTH_W-1:0]      month;
		logic [NDAY_W-1:0]        day;
		logic                     overflow;
	} norm_date_t;

	logic clk;
	logic arst_n;

	cdn_raw_if  raw_ch ();
	cdn_norm_if norm_ch ();

	calendar_date_normalizer_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.date_raw  (raw_ch),
		.date_norm (norm_ch)
	);

	// Dates in flight, oldest first.
	norm_date_t expected_dates [$];
	int         mismatch_count;
	int         quiet_cycles;
	int         stall_left;
	// Random idling on the raw side and stalls on the normalized side.
	bit         sender_idles;
	bit         sink_idles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Gregorian leap rule; works for negative years as well since only
	// "remainder is zero" is tested (0, -4, -400 leap, -100 not).
	function automatic bit leap_year(input int yr);
		return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
	endfunction

	function automatic int days_in_month(input int yr, input int mo);
		if (mo == 2 && leap_year(yr))
			return 29;
		return DAYS_PER_MONTH[mo - 1];
	endfunction

	// Full normalization on an unbounded year; only the final year is clamped.
	function automatic norm_date_t normalize_date(input logic signed [YEAR_W-1:0] ry,
		input logic signed [MONTH_W-1:0] rm, input logic signed [DAY_W-1:0] rd);
		int         yr;
		int         mo;
		int         dy;
		int         carry;
		norm_date_t res;
		yr = int'(ry);
		mo = int'(rm) - 1;
		dy = int'(rd);
		// floor division by 12; '/' truncates toward zero
		carry = mo / 12;
		if (mo % 12 < 0)
			carry = carry - 1;
		mo = mo - carry * 12 + 1;
		yr = yr + carry;
		while (dy > days_in_month(yr, mo)) begin
			dy = dy - days_in_month(yr, mo);
			mo = mo + 1;
			if (mo > 12) begin
				mo = 1;
				yr = yr + 1;
			end
		end
		while (dy < 1) begin
			mo = mo - 1;
			if (mo < 1) begin
				mo = 12;
				yr = yr - 1;
			end
			dy = dy + days_in_month(yr, mo);
		end
		res.overflow = 1'b0;
		if (yr > 32767) begin
			yr = 32767;
			res.overflow = 1'b1;
		end else if (yr < -32768) begin
			yr = -32768;
			res.overflow = 1'b1;
		end
		res.year  = yr[YEAR_W-1:0];
		res.month = mo[NMONTH_W-1:0];
		res.day   = dy[NDAY_W-1:0];
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Result checking: every accepted normalized item against the oldest
	// prediction. Samples pre-edge values, so no race with the DUT flops.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		norm_date_t want;
		if (arst_n && norm_ch.valid && norm_ch.ready) begin
			if (expected_dates.size() == 0) begin
				$display("%0t: unexpected item: year %0d month %0d day %0d ovf %0b", $time,
					norm_ch.norm_year, norm_ch.norm_month, norm_ch.norm_day,
					norm_ch.year_overflow);
				mismatch_count++;
			end else begin
				want = expected_dates.pop_front();
				if (norm_ch.norm_year !== want.year) begin
					$display("%0t: norm_year expected %0d actual %0d", $time,
						want.year, norm_ch.norm_year);
					mismatch_count++;
				end
				if (norm_ch.norm_month !== want.month) begin
					$display("%0t: norm_month expected %0d actual %0d", $time,
						want.month, norm_ch.norm_month);
					mismatch_count++;
				end
				if (norm_ch.norm_day !== want.day) begin
					$display("%0t: norm_day expected %0d actual %0d", $time,
						want.day, norm_ch.norm_day);
					mismatch_count++;
				end
				if (norm_ch.year_overflow !== want.overflow) begin
					$display("%0t: year_overflow expected %0b actual %0b", $time,
						want.overflow, norm_ch.year_overflow);
					mismatch_count++;
				end
			end
		end
	end

	// Output-side backpressure: random stall bursts while sink_idles is set.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			norm_ch.ready <= 1'b0;
			stall_left    <= stall_left - 1;
		end else if (sink_idles && $urandom_range(0, 7) == 0) begin
			norm_ch.ready <= 1'b0;
			stall_left    <= $urandom_range(0, 10);
		end else begin
			norm_ch.ready <= 1'b1;
		end
	end

	// Watchdog: a long walk still ends in an accept well inside the limit.
	always @(posedge clk) begin
		if (!arst_n || (raw_ch.valid && raw_ch.ready) || (norm_ch.valid && norm_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("calendar_date_normalizer_core verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Offers one raw date and returns at the edge where it is taken. valid is
	// left high so a back-to-back item does not toggle it within one step.
	task automatic send_date(input logic signed [YEAR_W-1:0] y,
		input logic signed [MONTH_W-1:0] m, input logic signed [DAY_W-1:0] d);
		norm_date_t want;
		int         gap;
		want = normalize_date(y, m, d);
		if (sender_idles && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			raw_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		raw_ch.valid     <= 1'b1;
		raw_ch.raw_year  <= y;
		raw_ch.raw_month <= m;
		raw_ch.raw_day   <= d;
		do
			@(posedge clk);
		while (!raw_ch.ready);
		expected_dates.push_back(want);
	endtask

	// Drop valid and hold off until every prediction has been matched.
	task automatic wait_drained();
		raw_ch.valid <= 1'b0;
		while (expected_dates.size() != 0)
			@(posedge clk);
	endtask

	// Field extremes, month fold both ways, widest day walks, year saturation.
	task automatic test_corners();
		send_date(0, 1, 1);
		send_date(32767, 12, 32);          // rolls past the top year
		send_date(-32768, 1, 0);           // rolls below the bottom year
		send_date(-32768, -8192, -131072); // everything at its negative extreme
		send_date(32767, 8191, 131071);    // everything at its positive extreme
		send_date(2024, 0, 0);
		send_date(2024, 13, 1);
		send_date(1, 8191, 1);
		send_date(1, -8192, 1);
		send_date(0, 1, 131071);
		send_date(0, 1, -131072);
		send_date(-1, 12, 31);
		send_date(100, 1, 366);
	endtask

	// Leap rule around February, including negative years.
	task automatic test_leap_rule();
		send_date(0, 2, 29);
		send_date(-4, 2, 29);
		send_date(-400, 2, 29);
		send_date(-100, 2, 29);            // not leap: becomes March 1
		send_date(1900, 2, 29);
		send_date(2000, 2, 29);
		send_date(2023, 3, 0);
		send_date(2024, 3, 0);
		send_date(-1, 3, 0);
	endtask

	// One random raw date, biased toward the interesting regions.
	task automatic random_date(output logic signed [YEAR_W-1:0] y,
		output logic signed [MONTH_W-1:0] m, output logic signed [DAY_W-1:0] d);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			y = $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 2))
				: 16'h8000 + 16'($urandom_range(0, 2));
		else
			y = YEAR_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 70)
			m = MONTH_W'($urandom_range(1, 12));
		else if (pick < 85)
			m = MONTH_W'(int'($urandom_range(0, 70)) - 30);
		else
			m = MONTH_W'($urandom);
		// full-width day offsets walk thousands of months; keep them a minority
		pick = $urandom_range(0, 99);
		if (pick < 60)
			d = DAY_W'(int'($urandom_range(0, 110)) - 40);
		else if (pick < 88)
			d = DAY_W'(int'($urandom_range(0, 1600)) - 800);
		else
			d = DAY_W'($urandom);
	endtask

	task automatic test_random_mix(input int count);
		logic signed [YEAR_W-1:0]  y;
		logic signed [MONTH_W-1:0] m;
		logic signed [DAY_W-1:0]   d;
		repeat (count) begin
			random_date(y, m, d);
			send_date(y, m, d);
		end
	endtask

	// Sender holds back until the pipeline is empty, then resumes.
	task automatic test_drain_pause();
		test_random_mix(10);
		wait_drained();
		test_random_mix(10);
	endtask

	// Back-to-back traffic, no idling on either side.
	task automatic test_steady_tail();
		sender_idles = 1'b0;
		sink_idles   = 1'b0;
		test_random_mix(40);
	endtask

	initial begin
		mismatch_count = 0;
		sender_idles   = 1'b1;
		sink_idles     = 1'b1;
		arst_n           <= 1'b0;
		raw_ch.valid     <= 1'b0;
		raw_ch.raw_year  <= '0;
		raw_ch.raw_month <= '0;
		raw_ch.raw_day   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		test_leap_rule();
		test_random_mix(200);
		test_drain_pause();
		test_steady_tail();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_dates.size() == 0)
			$display("calendar_date_normalizer_core verification clean");
		else
			$display("calendar_date_normalizer_core verification failed");
		$finish;
	end

endmodule
